### hdl/dcf_pkg.sv
// ----------------------------------------------------------------------------
// dcf_pkg
// Shared types, constants and helpers of the dynamic channel fragmenter.
// ----------------------------------------------------------------------------
package dcf_pkg;

	// PDU command codes (upper nibble of the header byte)
	localparam logic [3:0] CMD_DATA_FIRST = 4'h2;
	localparam logic [3:0] CMD_DATA       = 4'h3;

	// Smallest usable chunk size and its reset value
	localparam logic [15:0] CHUNK_FLOOR = 16'd16;
	localparam logic [15:0] CHUNK_RESET = 16'd1600;

	// Configuration register indexes
	localparam logic REG_CHUNK_SIZE = 1'b0;

	// Default depth of the request queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// One request handed from the front to the back
	typedef struct packed {
		logic [7:0]  data;   // payload byte
		logic        last;   // payload byte closes its PDU
		logic        hdr;    // open a PDU: emit header and id first
		logic        df;     // the opened PDU is DATA_FIRST
		logic [31:0] chan;   // channel id
		logic [31:0] len;    // bytes remaining, announced in DATA_FIRST
	} dcf_entry_t;

	// Byte count of a variable-sized field
	function automatic logic [2:0] var_len(input logic [31:0] v);
		logic [2:0] n;
		if (v[31:8] == 24'd0) begin
			n = 3'd1;
		end else if (v[31:16] == 16'd0) begin
			n = 3'd2;
		end else begin
			n = 3'd4;
		end
		return n;
	endfunction

	// Size code of a variable-sized field
	function automatic logic [1:0] var_code(input logic [31:0] v);
		logic [1:0] c;
		if (v[31:8] == 24'd0) begin
			c = 2'd0;
		end else if (v[31:16] == 16'd0) begin
			c = 2'd1;
		end else begin
			c = 2'd2;
		end
		return c;
	endfunction

endpackage

### hdl/dcf_front.sv
// ----------------------------------------------------------------------------
// dcf_front
// Accepts payload bytes, tracks message and PDU bookkeeping, and turns each
// byte that belongs to a message into one request for the back end.
// ----------------------------------------------------------------------------
module dcf_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [15:0]        chunk_size,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [7:0]         data_byte,
	input  logic               start_of_message,
	input  logic [31:0]        chan_id,
	input  logic [31:0]        message_length,
	output logic               push,
	output dcf_pkg::dcf_entry_t push_entry
);
	import dcf_pkg::*;

	logic [31:0] bytes_remaining_q;
	logic [15:0] room_left_q;
	logic        first_chunk_q;
	logic [31:0] held_channel_q;

	logic [31:0] held_n;
	logic [31:0] rem_n;
	logic [15:0] room_n;
	logic        first_n;
	logic        active;
	logic        open_pdu;
	logic [15:0] cs;
	logic [15:0] room0;
	logic [15:0] room1;
	logic [15:0] room_use;
	logic        df;
	logic [31:0] rem_dec;
	logic [15:0] room_dec;
	logic        accept;

	assign accept = in_valid && in_ready;

	// Apply a message start before anything else
	always_comb begin
		held_n  = start_of_message ? chan_id        : held_channel_q;
		rem_n   = start_of_message ? message_length : bytes_remaining_q;
		room_n  = start_of_message ? 16'd0          : room_left_q;
		first_n = start_of_message ? 1'b1           : first_chunk_q;
	end

	// Size the PDU that opens on this byte
	always_comb begin
		active   = (rem_n != 32'd0);
		open_pdu = (room_n == 16'd0);
		cs       = (chunk_size < CHUNK_FLOOR) ? CHUNK_FLOOR : chunk_size;
		room0    = cs - 16'd1 - {13'd0, var_len(held_n)};
		df       = first_n && open_pdu && (rem_n > {16'd0, room0});
		room1    = df ? (room0 - {13'd0, var_len(rem_n)}) : room0;
		room_use = open_pdu ? room1 : room_n;
		rem_dec  = rem_n - 32'd1;
		room_dec = (rem_dec == 32'd0) ? 16'd0 : (room_use - 16'd1);
	end

	// Hand a request to the back for every byte that belongs to a message
	assign push            = accept && active;
	assign push_entry.data = data_byte;
	assign push_entry.last = (room_dec == 16'd0);
	assign push_entry.hdr  = open_pdu;
	assign push_entry.df   = df;
	assign push_entry.chan = held_n;
	assign push_entry.len  = rem_n;

	// Advance message state on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_remaining_q <= 32'd0;
			room_left_q       <= 16'd0;
			first_chunk_q     <= 1'b0;
			held_channel_q    <= 32'd0;
		end else if (accept) begin
			held_channel_q <= held_n;
			if (active) begin
				bytes_remaining_q <= rem_dec;
				room_left_q       <= room_dec;
				first_chunk_q     <= open_pdu ? 1'b0 : first_n;
			end else begin
				bytes_remaining_q <= rem_n;
				room_left_q       <= room_n;
				first_chunk_q     <= first_n;
			end
		end
	end

	// No PDU stays open once the message is complete
	a_closed_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		(bytes_remaining_q == 32'd0) |-> (room_left_q == 16'd0))
		else $error("open PDU with no message bytes left");

endmodule

### hdl/dcf_queue.sv
// ----------------------------------------------------------------------------
// dcf_queue
// Small register queue of requests between the front and the back end.
// ----------------------------------------------------------------------------
module dcf_queue #(
	parameter int DEPTH = dcf_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  dcf_pkg::dcf_entry_t push_entry,
	output logic                full,
	input  logic                pop,
	output logic                head_valid,
	output dcf_pkg::dcf_entry_t head_entry
);
	import dcf_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	dcf_entry_t    slots_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = slots_q[rd_ptr_q];

	// Store pushed requests
	always_ff @(posedge clk) begin
		if (push && !full) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop && head_valid) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push && !full, pop && head_valid})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count beyond depth");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (rd_ptr_q == wr_ptr_q))
		else $error("empty queue with pointers apart");

	a_no_lost_push: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("request pushed into a full queue");

endmodule

### hdl/dcf_back.sv
// ----------------------------------------------------------------------------
// dcf_back
// Serializes each request into bytes: header byte, channel id, total length
// for DATA_FIRST, then payload byte (alone if no hdr), to an output register.
// ----------------------------------------------------------------------------
module dcf_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  dcf_pkg::dcf_entry_t head_entry,
	output logic                pop,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [7:0]          m_tdata,
	output logic                m_tlast
);
	import dcf_pkg::*;

	logic [3:0] pos_q;
	logic       m_tvalid_q;
	logic [7:0] m_tdata_q;
	logic       m_tlast_q;

	logic [2:0] cl;
	logic [2:0] ll;
	logic [3:0] pay_idx;
	logic [3:0] off_chan;
	logic [3:0] off_len;
	logic [7:0] hdr_byte;
	logic [7:0] sel_byte;
	logic       sel_last;
	logic       final_byte;
	logic       load;

	// Pick the byte at the current position of the request
	always_comb begin
		cl       = var_len(head_entry.chan);
		ll       = head_entry.df ? var_len(head_entry.len) : 3'd0;
		pay_idx  = head_entry.hdr ? (4'd1 + {1'b0, cl} + {1'b0, ll}) : 4'd0;
		off_chan = pos_q - 4'd1;
		off_len  = pos_q - 4'd1 - {1'b0, cl};
		if (head_entry.df) begin
			hdr_byte = {CMD_DATA_FIRST, var_code(head_entry.len), var_code(head_entry.chan)};
		end else begin
			hdr_byte = {CMD_DATA, 2'd0, var_code(head_entry.chan)};
		end
		final_byte = (pos_q == pay_idx);
		sel_last   = 1'b0;
		if (final_byte) begin
			sel_byte = head_entry.data;
			sel_last = head_entry.last;
		end else if (pos_q == 4'd0) begin
			sel_byte = hdr_byte;
		end else if (pos_q <= {1'b0, cl}) begin
			sel_byte = head_entry.chan[{off_chan[1:0], 3'b000} +: 8];
		end else begin
			sel_byte = head_entry.len[{off_len[1:0], 3'b000} +: 8];
		end
	end

	assign load = head_valid && (!m_tvalid_q || m_tready);
	assign pop  = load && final_byte;

	// Step through the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 4'd0;
		end else if (load) begin
			pos_q <= final_byte ? 4'd0 : pos_q + 4'd1;
		end
	end

	// Hold the outgoing byte until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_tdata_q <= sel_byte;
			m_tlast_q <= sel_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= 4'd9)
		else $error("serializer position beyond longest PDU opening");

	a_mid_header: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q != 4'd0) |-> (head_valid && head_entry.hdr))
		else $error("header in progress without a header request");

endmodule

### hdl/dynamic_channel_fragmenter.sv
// ----------------------------------------------------------------------------
// dynamic_channel_fragmenter
// Splits messages into dynamic virtual channel PDUs of at most chunk_size
// bytes.
// ----------------------------------------------------------------------------
// Payload bytes enter on the s_ stream one per cycle while the request
// queue is not full; a byte with s_tuser high starts a message and samples
// its channel id and total length. The m_ stream carries PDU bytes, m_tlast
// on the last byte of each PDU. A payload byte that carries on an open PDU
// yields one output byte; the byte that opens a PDU yields a header byte,
// 1, 2 or 4 id bytes, 1, 2 or 4 length bytes for DATA_FIRST and itself, so
// 3 to 10 bytes, from the back end serializer that emits one byte per cycle
// while m_tready allows. A four-entry request queue lets input go on while
// a header is serialized. chunk_size sits at address 0 of the APB port;
// values below 16 act as 16. Bytes past the announced length are dropped.
module dynamic_channel_fragmenter #(
	parameter int QUEUE_DEPTH = dcf_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	// payload in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // data_byte[7:0], chan_id[39:8], message_length[71:40]
	input  logic        s_tuser,   // start_of_message
	// PDU bytes out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // out_byte[7:0]
	output logic        m_tlast,   // end_of_pdu
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import dcf_pkg::*;

	logic [15:0] chunk_size_q;
	logic        push;
	dcf_entry_t  push_entry;
	logic        full;
	logic        pop;
	logic        head_valid;
	dcf_entry_t  head_entry;

	// Register write and readback
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_size_q <= CHUNK_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_CHUNK_SIZE)) begin
			chunk_size_q <= pwdata[15:0];
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_CHUNK_SIZE: prdata = {16'd0, chunk_size_q};
			default:        prdata = 32'd0;
		endcase
	end

	assign s_tready = !full;

	dcf_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.chunk_size       (chunk_size_q),
		.in_valid         (s_tvalid),
		.in_ready         (s_tready),
		.data_byte        (s_tdata[7:0]),
		.start_of_message (s_tuser),
		.chan_id          (s_tdata[39:8]),
		.message_length   (s_tdata[71:40]),
		.push             (push),
		.push_entry       (push_entry)
	);

	dcf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	dcf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule
